### hdl/uartrxq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrxq_pkg
// Shared types and constants for the four-lane 3x oversampled UART receiver.
// ----------------------------------------------------------------------------
package uartrxq_pkg;

  localparam int unsigned LANES       = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BIT_IDX_W   = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_ON_BYTE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_BYTE = 1'd1;

  // Register reset values
  localparam logic [BYTE_W-1:0] ON_BYTE_RST  = 8'b1001_0000;
  localparam logic [BYTE_W-1:0] OFF_BYTE_RST = 8'b1000_0000;

  // Frame sequencer phases; data bit index is kept in a separate counter
  typedef enum logic [11:0] {
    PH_INITIAL     = 12'b0000_0000_0001,
    PH_IDLE_1      = 12'b0000_0000_0010,
    PH_IDLE_11     = 12'b0000_0000_0100,
    PH_START_0     = 12'b0000_0000_1000,
    PH_START_00    = 12'b0000_0001_0000,
    PH_GAP_A       = 12'b0000_0010_0000,
    PH_GAP_B       = 12'b0000_0100_0000,
    PH_CAP         = 12'b0000_1000_0000,
    PH_STOP_GAP_0  = 12'b0001_0000_0000,
    PH_STOP_GAP_00 = 12'b0010_0000_0000,
    PH_STOP_1      = 12'b0100_0000_0000,
    PH_STOP_11     = 12'b1000_0000_0000
  } phase_t;

  // What one lane reports to the merge stage each tick
  typedef struct packed {
    logic              done;   // frame completes on this sample
    logic [BYTE_W-1:0] data;   // assembled byte held by the lane
  } lane_rpt_t;

  // Configuration write
  typedef struct packed {
    logic                 wr;
    logic [CFG_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]    data;
  } cfg_wr_t;

endpackage

### hdl/uartrxq_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrxq_lane
// One receive lane: frame sequencer plus LSB-first shift register.
// ----------------------------------------------------------------------------
module uartrxq_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   sample,
  output uartrxq_pkg::lane_rpt_t rpt
);
  import uartrxq_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [BIT_IDX_W-1:0]   bit_r, bit_nxt;
  logic [BYTE_W-1:0]      shift_r;
  phase_t                 brk;

  // Next phase of the frame table
  always_comb begin
    brk       = sample ? PH_IDLE_1 : PH_INITIAL;
    phase_nxt = brk;
    bit_nxt   = bit_r;
    case (phase_r)
      PH_INITIAL:     phase_nxt = sample ? PH_IDLE_1 : PH_INITIAL;
      PH_IDLE_1:      phase_nxt = sample ? PH_IDLE_11 : PH_INITIAL;
      PH_IDLE_11:     phase_nxt = sample ? PH_IDLE_11 : PH_START_0;
      PH_START_0:     phase_nxt = sample ? brk : PH_START_00;
      PH_START_00: begin
        phase_nxt = PH_GAP_A;
        bit_nxt   = '0;
      end
      PH_GAP_A:       phase_nxt = PH_GAP_B;
      PH_GAP_B:       phase_nxt = PH_CAP;
      PH_CAP: begin
        if (bit_r == {BIT_IDX_W{1'b1}}) begin
          phase_nxt = PH_STOP_GAP_0;
        end else begin
          phase_nxt = PH_GAP_A;
          bit_nxt   = bit_r + 1'b1;
        end
      end
      PH_STOP_GAP_0:  phase_nxt = sample ? PH_STOP_1 : PH_STOP_GAP_00;
      PH_STOP_GAP_00: phase_nxt = sample ? PH_STOP_1 : PH_INITIAL;
      PH_STOP_1:      phase_nxt = sample ? PH_STOP_11 : PH_INITIAL;
      PH_STOP_11:     phase_nxt = sample ? PH_IDLE_11 : PH_START_0;
      default:        phase_nxt = brk;
    endcase
  end

  // Advance the sequencer on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INITIAL;
      bit_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // Capture the middle sample of each data bit from the top
  always_ff @(posedge clk) begin
    if (step && phase_nxt == PH_CAP) begin
      shift_r <= {sample, shift_r[BYTE_W-1:1]};
    end
  end

  assign rpt.done = (phase_nxt == PH_STOP_11);
  assign rpt.data = shift_r;

endmodule

### hdl/uartrxq_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrxq_merge
// Match registers and shared indicator; highest completing lane decides.
// ----------------------------------------------------------------------------
module uartrxq_merge (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  uartrxq_pkg::cfg_wr_t   cfg,
  input  uartrxq_pkg::lane_rpt_t rpt [uartrxq_pkg::LANES],
  output logic                   indicator
);
  import uartrxq_pkg::*;

  logic [BYTE_W-1:0] on_byte_r, off_byte_r;
  logic              ind_r, ind_nxt;

  // Hold the match registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_byte_r  <= ON_BYTE_RST;
      off_byte_r <= OFF_BYTE_RST;
    end else if (cfg.wr) begin
      case (cfg.idx)
        REG_ON_BYTE:  on_byte_r  <= cfg.data;
        REG_OFF_BYTE: off_byte_r <= cfg.data;
        default: ;
      endcase
    end
  end

  // Walk lanes low to high so the highest completion wins
  always_comb begin
    ind_nxt = ind_r;
    for (int k = 0; k < LANES; k++) begin
      if (rpt[k].done) begin
        if (rpt[k].data == on_byte_r) begin
          ind_nxt = 1'b1;
        end else if (rpt[k].data == off_byte_r) begin
          ind_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ind_r <= 1'b0;
    end else if (step) begin
      ind_r <= ind_nxt;
    end
  end

  assign indicator = ind_r;

endmodule

### hdl/oversampled_uart_rx_quad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oversampled_uart_rx_quad
// Four 8N1 receivers at 3x oversampling with a shared on/off indicator.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per oversampling tick; in_tdata[3:0] holds one
//           sample of the four lines, bit k for lane k.
//   out_* : one transfer per input transfer; carries the lanes that finished
//           a frame on that tick, each lane's last assembled byte and the
//           indicator level after the tick.
//   cfg_* : register writes (index 0 on_byte, index 1 off_byte), always
//           accepted; write only while no result is pending.
// A result is valid in the cycle after its sample is accepted.
// Throughput is one sample per cycle unless stalled; each lane does one table
// step per tick and the merge stage resolves the indicator in the same cycle.
// When the receiver stalls, the result register holds and in_tready drops
// until it is taken; a result taken in a cycle frees room for a new sample
// in that same cycle.
// Reset puts every lane in its initial state, clears the indicator and
// loads on_byte = 0x90, off_byte = 0x80. Lane bytes are meaningless until
// that lane has captured eight bits.
// ----------------------------------------------------------------------------
module oversampled_uart_rx_quad (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // line_sample[3:0], zero padded
  input  logic [uartrxq_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // byte_ready[3:0], lane0_byte[11:4], lane1_byte[19:12], lane2_byte[27:20],
  // lane3_byte[35:28], indicator[36], zero padded
  output logic [uartrxq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [uartrxq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uartrxq_pkg::BYTE_W-1:0]        cfg_data
);
  import uartrxq_pkg::*;

  logic              in_xfer;
  logic              out_valid_r, out_valid_nxt;
  logic [LANES-1:0]  ready_r;
  logic [LANES-1:0]  done;
  lane_rpt_t         rpt [LANES];
  cfg_wr_t           cfg;
  logic              indicator;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign cfg.wr   = cfg_valid && cfg_ready;
  assign cfg.idx  = cfg_index;
  assign cfg.data = cfg_data;

  // Lanes
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    uartrxq_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .step   (in_xfer),
      .sample (in_tdata[k]),
      .rpt    (rpt[k])
    );
    assign done[k] = rpt[k].done;
  end

  uartrxq_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_xfer),
    .cfg       (cfg),
    .rpt       (rpt),
    .indicator (indicator)
  );

  // Result valid: set on an input transfer, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold completion flags alongside the result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ready_r <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, indicator,
                       rpt[3].data, rpt[2].data, rpt[1].data, rpt[0].data,
                       ready_r};

  // An accepted sample always yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("no result after accepted sample");

  // An empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input blocked with empty result register");

  // The indicator only moves on a tick where some lane completed a frame
  a_ind_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && indicator != $past(indicator)) |->
      ($past(in_xfer) && ready_r != '0))
    else $error("indicator changed without a completed frame");

endmodule

### test/oversampled_uart_rx_quad_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oversampled_uart_rx_quad_tb
// Self-checking bench for the four-lane 3x oversampled UART receiver.
// Serial frames are built per lane, aligned or staggered, and mixed with noise
// and broken frames. Each accepted sample is run through a sample-level model
// of the frame sequencer. Every result transfer is checked against it.
// The run goes through several indicator byte settings and back-pressure
// patterns on both streams.
// ----------------------------------------------------------------------------
module oversampled_uart_rx_quad_tb;
  import uartrxq_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 5;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 210;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 4;

  // Expected content of one result transfer
  typedef struct {
    logic [LANES-1:0]  ready;
    logic [BYTE_W-1:0] lane [LANES];
    logic [LANES-1:0]  known;   // lane byte holds eight captured bits
    logic              ind;
  } tick_result_t;

  // Frame sequencer model for all four lanes plus the shared indicator
  class lane_frame_tracker;
    logic [BYTE_W-1:0]    on_byte;
    logic [BYTE_W-1:0]    off_byte;
    phase_t               ph [LANES];
    logic [BIT_IDX_W-1:0] bit_idx [LANES];
    logic [BYTE_W-1:0]    shift [LANES];
    int                   captures [LANES];
    logic                 ind_level;
    tick_result_t         pending_ticks [$];
    int                   errors;

    function new();
      on_byte   = ON_BYTE_RST;
      off_byte  = OFF_BYTE_RST;
      ind_level = 1'b0;
      errors    = 0;
      for (int k = 0; k < LANES; k++) begin
        ph[k]       = PH_INITIAL;
        bit_idx[k]  = '0;
        shift[k]    = '0;
        captures[k] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      if (idx == REG_ON_BYTE) on_byte = data;
      else if (idx == REG_OFF_BYTE) off_byte = data;
    endfunction

    function int pending();
      return pending_ticks.size();
    endfunction

    // Advance every lane by one sample and queue the expected transfer
    function void take_sample(logic [IN_TDATA_W-1:0] sample);
      tick_result_t res;
      logic         hi;
      logic         cap;
      logic         done;
      phase_t       nxt;
      res.ready = '0;
      res.known = '0;
      for (int k = 0; k < LANES; k++) begin
        hi   = sample[k];
        cap  = 1'b0;
        done = 1'b0;
        case (ph[k])
          PH_INITIAL:     nxt = hi ? PH_IDLE_1 : PH_INITIAL;
          PH_IDLE_1:      nxt = hi ? PH_IDLE_11 : PH_INITIAL;
          PH_IDLE_11:     nxt = hi ? PH_IDLE_11 : PH_START_0;
          PH_START_0:     nxt = hi ? PH_IDLE_1 : PH_START_00;
          PH_START_00: begin
            nxt        = PH_GAP_A;
            bit_idx[k] = '0;
          end
          PH_GAP_A:       nxt = PH_GAP_B;
          PH_GAP_B: begin
            nxt = PH_CAP;
            cap = 1'b1;
          end
          PH_CAP: begin
            if (bit_idx[k] == BIT_IDX_W'(BYTE_W - 1)) begin
              nxt = PH_STOP_GAP_0;
            end else begin
              nxt        = PH_GAP_A;
              bit_idx[k] = bit_idx[k] + 1'b1;
            end
          end
          PH_STOP_GAP_0:  nxt = hi ? PH_STOP_1 : PH_STOP_GAP_00;
          PH_STOP_GAP_00: nxt = hi ? PH_STOP_1 : PH_INITIAL;
          PH_STOP_1: begin
            nxt  = hi ? PH_STOP_11 : PH_INITIAL;
            done = hi;
          end
          PH_STOP_11:     nxt = hi ? PH_IDLE_11 : PH_START_0;
          default:        nxt = hi ? PH_IDLE_1 : PH_INITIAL;
        endcase
        ph[k] = nxt;
        if (cap) begin
          shift[k] = {hi, shift[k][BYTE_W-1:1]};
          if (captures[k] < BYTE_W) captures[k]++;
        end
        // on_byte is tested first; the highest lane finishing decides
        if (done) begin
          res.ready[k] = 1'b1;
          if (shift[k] == on_byte) ind_level = 1'b1;
          else if (shift[k] == off_byte) ind_level = 1'b0;
        end
        res.lane[k]  = shift[k];
        res.known[k] = (captures[k] >= BYTE_W);
      end
      res.ind = ind_level;
      pending_ticks.push_back(res);
    endfunction

    function void flag(string field, logic [BYTE_W-1:0] exp_v, logic [BYTE_W-1:0] act_v);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch %s: expected %0h, got %0h", field, exp_v, act_v);
    endfunction

    // Compare one result transfer against the oldest expectation
    function void match_result(logic [OUT_TDATA_W-1:0] tdata);
      tick_result_t res;
      logic [BYTE_W-1:0] got;
      if (pending_ticks.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result transfer: %0h", tdata);
        return;
      end
      res = pending_ticks.pop_front();
      if (tdata[LANES-1:0] != res.ready)
        flag("byte_ready", BYTE_W'(res.ready), BYTE_W'(tdata[LANES-1:0]));
      for (int k = 0; k < LANES; k++) begin
        got = tdata[LANES + BYTE_W*k +: BYTE_W];
        if (res.known[k] && got != res.lane[k])
          flag($sformatf("lane%0d_byte", k), res.lane[k], got);
      end
      if (tdata[LANES + BYTE_W*LANES] != res.ind)
        flag("indicator", BYTE_W'(res.ind), BYTE_W'(tdata[LANES + BYTE_W*LANES]));
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [BYTE_W-1:0]      cfg_data   = '0;

  lane_frame_tracker sb;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                cycle_count    = 0;
  logic [LANES-1:0]  burst_q [$];
  logic [IN_TDATA_W-1:0] directed_q [$] = '{8'h00, 8'h0F, 8'h00, 8'h05, 8'h0A, 8'hF0,
                                            8'hFF, 8'h0F, 8'h0F, 8'h03, 8'h0C, 8'hA5};

  oversampled_uart_rx_quad uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Randomize receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.match_result(out_tdata);
  end

  // Place one lane level at a burst position, growing the burst with idle highs
  function automatic int put_bit(int k, int p, logic v);
    logic [LANES-1:0] w;
    if (p >= burst_q.size()) burst_q.push_back('1);
    w        = burst_q[p];
    w[k]     = v;
    burst_q[p] = w;
    return p + 1;
  endfunction

  // Build one burst: a frame or noise on each lane, padded with idle highs
  task automatic build_burst();
    int               lead;
    int               lane_lead;
    int               p;
    int               flaw;
    int               pick;
    logic             glitch;
    logic             aligned;
    logic [BYTE_W-1:0] val;
    aligned = $urandom_range(1);
    lead    = $urandom_range(5);
    for (int k = 0; k < LANES; k++) begin
      p         = 0;
      lane_lead = aligned ? lead : $urandom_range(5);
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(40, 5)) p = put_bit(k, p, $urandom_range(1));
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) val = sb.on_byte;
        else if (pick < 70) val = sb.off_byte;
        else val = BYTE_W'($urandom);
        glitch = ($urandom_range(3) == 0);
        flaw   = $urandom_range(7);
        repeat (lane_lead) p = put_bit(k, p, 1'b1);
        // start bit; a high second sample breaks the frame
        p = put_bit(k, p, 1'b0);
        p = put_bit(k, p, (flaw == 0));
        p = put_bit(k, p, glitch ? 1'($urandom) : 1'b0);
        // data bits; only the middle sample is captured
        for (int j = 0; j < BYTE_W; j++) begin
          p = put_bit(k, p, glitch ? 1'($urandom) : val[j]);
          p = put_bit(k, p, val[j]);
          p = put_bit(k, p, glitch ? 1'($urandom) : val[j]);
        end
        // stop bit: late, on time, or missing
        if (flaw == 1) begin
          p = put_bit(k, p, 1'b0);
          p = put_bit(k, p, 1'b0);
        end else begin
          if ($urandom_range(3) == 0) p = put_bit(k, p, 1'b0);
          p = put_bit(k, p, 1'b1);
          p = put_bit(k, p, 1'b1);
        end
      end
    end
  endtask

  // Offer one sample until it is taken, then idle at random
  task automatic drive_sample(input logic [IN_TDATA_W-1:0] d);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.take_sample(d);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);
      @(negedge clk);
    end
  endtask

  // Hold the input until every expected result has arrived
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Write both indicator bytes back to back
  task automatic write_regs(input logic [BYTE_W-1:0] on_v, input logic [BYTE_W-1:0] off_v);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ON_BYTE;
    cfg_data  <= on_v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_ON_BYTE, on_v);
    @(negedge clk);
    cfg_index <= REG_OFF_BYTE;
    cfg_data  <= off_v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_OFF_BYTE, off_v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [BYTE_W-1:0]     phase_on  [PHASES];
    logic [BYTE_W-1:0]     phase_off [PHASES];
    int                    phase_send [PHASES];
    int                    phase_recv [PHASES];
    int                    n;
    logic [LANES-1:0]      upper;
    sb = new();
    phase_on   = '{ON_BYTE_RST, 8'h00, 8'hFF, 8'h5A, 8'h00};
    phase_off  = '{OFF_BYTE_RST, 8'hFF, 8'h00, 8'h5A, 8'h00};
    phase_send = '{0, 75, 0, 31, 0};
    phase_recv = '{0, 0, 75, 31, 0};
    phase_on[4]  = BYTE_W'($urandom);
    phase_off[4] = BYTE_W'($urandom);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extreme line levels, ignored upper bits
    foreach (directed_q[i]) drive_sample(directed_q[i]);

    for (int ph_i = 0; ph_i < PHASES; ph_i++) begin
      settle();
      burst_q.delete();
      // keep reset values in the first phase
      if (ph_i != 0) write_regs(phase_on[ph_i], phase_off[ph_i]);
      send_idle_pct  = phase_send[ph_i];
      recv_stall_pct = phase_recv[ph_i];
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (burst_q.size() == 0) build_burst();
        upper = ($urandom_range(19) == 0) ? LANES'($urandom) : '0;
        drive_sample({upper, burst_q.pop_front()});
        n++;
        if (n == PHASE_ITEMS / 2) settle();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
